@@ rtl/core/sbs_pkg.sv @@
// ----------------------------------------------------------------------------
// Segment/box slab test package
// Shared widths for the slab test datapath and its divider lanes.
// ----------------------------------------------------------------------------
package sbs_pkg;
	localparam int COORD_W = 32;          // signed fixed-point coordinate
	localparam int DIFF_W  = COORD_W + 1; // exact difference of two coordinates
	localparam int EPS_W   = 16;          // parallel threshold register
endpackage

@@ rtl/core/segment_box_slab_test.sv @@
// ----------------------------------------------------------------------------
// Segment/box slab test
// Intersects a line segment with an axis-aligned box, t clamped to [0,1].
// ----------------------------------------------------------------------------
// Accepts one segment/box query every cycle and returns one result word per
// query in order: one input stage, a divider chain that resolves one
// quotient bit per step (FRAC_BITS + 3 stages with its registers, this
// sets the depth), then an ordering stage and the output register. The
// whole pipeline stalls together while a result waits on out_ready.
module segment_box_slab_test #(
	parameter int FRAC_BITS = 16,
	parameter int NUM_AXES  = 3
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sbs_pkg::EPS_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [sbs_pkg::COORD_W-1:0] start_x,
	input  logic signed [sbs_pkg::COORD_W-1:0] start_y,
	input  logic signed [sbs_pkg::COORD_W-1:0] start_z,
	input  logic signed [sbs_pkg::COORD_W-1:0] end_x,
	input  logic signed [sbs_pkg::COORD_W-1:0] end_y,
	input  logic signed [sbs_pkg::COORD_W-1:0] end_z,
	input  logic signed [sbs_pkg::COORD_W-1:0] box_lo_x,
	input  logic signed [sbs_pkg::COORD_W-1:0] box_lo_y,
	input  logic signed [sbs_pkg::COORD_W-1:0] box_lo_z,
	input  logic signed [sbs_pkg::COORD_W-1:0] box_hi_x,
	input  logic signed [sbs_pkg::COORD_W-1:0] box_hi_y,
	input  logic signed [sbs_pkg::COORD_W-1:0] box_hi_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic [FRAC_BITS:0]                t_enter,
	output logic [FRAC_BITS:0]                t_exit
);
	import sbs_pkg::*;

	localparam int QW  = FRAC_BITS + 3;
	localparam int LAT = FRAC_BITS + 3;
	localparam logic signed [QW-1:0] T_ONE = QW'(1 << FRAC_BITS);

	logic en;
	logic [EPS_W-1:0] parallel_epsilon_q;

	logic signed [COORD_W-1:0] s_in  [0:2];
	logic signed [COORD_W-1:0] e_in  [0:2];
	logic signed [COORD_W-1:0] lo_in [0:2];
	logic signed [COORD_W-1:0] hi_in [0:2];

	logic                     vld_s1;
	logic signed [DIFF_W-1:0] d_s1     [0:NUM_AXES-1];
	logic signed [DIFF_W-1:0] dlo_s1   [0:NUM_AXES-1];
	logic signed [DIFF_W-1:0] dhi_s1   [0:NUM_AXES-1];
	logic [NUM_AXES-1:0]      par_s1;
	logic [NUM_AXES-1:0]      pmiss_s1;

	logic                vld_s2   [0:LAT-1];
	logic [NUM_AXES-1:0] par_s2   [0:LAT-1];
	logic [NUM_AXES-1:0] pmiss_s2 [0:LAT-1];

	logic signed [QW-1:0] q0 [0:NUM_AXES-1];
	logic signed [QW-1:0] q1 [0:NUM_AXES-1];

	logic                 vld_s3;
	logic signed [QW-1:0] ta_s3 [0:NUM_AXES-1];
	logic signed [QW-1:0] tb_s3 [0:NUM_AXES-1];
	logic                 miss_s3;

	logic signed [QW-1:0] lo_t;
	logic signed [QW-1:0] hi_t;

	assign s_in  = '{start_x, start_y, start_z};
	assign e_in  = '{end_x, end_y, end_z};
	assign lo_in = '{box_lo_x, box_lo_y, box_lo_z};
	assign hi_in = '{box_hi_x, box_hi_y, box_hi_z};

	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			parallel_epsilon_q <= '0;
		else if (cfg_valid)
			parallel_epsilon_q <= cfg_data;
	end

	// input stage: exact differences and the parallel-axis checks
	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		logic signed [DIFF_W-1:0] d_c;
		logic [DIFF_W-1:0]        mag_c;
		always_comb begin
			d_c   = DIFF_W'(e_in[a]) - DIFF_W'(s_in[a]);
			mag_c = d_c[DIFF_W-1] ? DIFF_W'(-d_c) : DIFF_W'(d_c);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				d_s1[a]     <= d_c;
				dlo_s1[a]   <= DIFF_W'(lo_in[a]) - DIFF_W'(s_in[a]);
				dhi_s1[a]   <= DIFF_W'(hi_in[a]) - DIFF_W'(s_in[a]);
				par_s1[a]   <= mag_c <= DIFF_W'(parallel_epsilon_q);
				pmiss_s1[a] <= (s_in[a] < lo_in[a]) || (s_in[a] > hi_in[a]);
			end
		end
		sbs_slab_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
			.clk(clk), .en(en), .diff(dlo_s1[a]), .d(d_s1[a]), .q(q0[a])
		);
		sbs_slab_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
			.clk(clk), .en(en), .diff(dhi_s1[a]), .d(d_s1[a]), .q(q1[a])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= in_valid;
	end

	// carry valid and parallel flags alongside the divider lanes
	for (genvar k = 0; k < LAT; k++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s2[k] <= 1'b0;
			else if (en)
				vld_s2[k] <= (k == 0) ? vld_s1 : vld_s2[(k == 0) ? 0 : k-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				par_s2[k]   <= (k == 0) ? par_s1 : par_s2[(k == 0) ? 0 : k-1];
				pmiss_s2[k] <= (k == 0) ? pmiss_s1 : pmiss_s2[(k == 0) ? 0 : k-1];
			end
		end
	end

	// order each axis pair; a parallel axis leaves the interval alone
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				if (par_s2[LAT-1][a]) begin
					ta_s3[a] <= '0;
					tb_s3[a] <= T_ONE;
				end else if (q0[a] > q1[a]) begin
					ta_s3[a] <= q1[a];
					tb_s3[a] <= q0[a];
				end else begin
					ta_s3[a] <= q0[a];
					tb_s3[a] <= q1[a];
				end
			end
			miss_s3 <= |(par_s2[LAT-1] & pmiss_s2[LAT-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (en)
			vld_s3 <= vld_s2[LAT-1];
	end

	always_comb begin
		lo_t = '0;
		hi_t = T_ONE;
		for (int a = 0; a < NUM_AXES; a++) begin
			if (ta_s3[a] > lo_t) lo_t = ta_s3[a];
			if (tb_s3[a] < hi_t) hi_t = tb_s3[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!miss_s3 && lo_t <= hi_t) begin
				hit     <= 1'b1;
				t_enter <= lo_t[FRAC_BITS:0];
				t_exit  <= hi_t[FRAC_BITS:0];
			end else begin
				hit     <= 1'b0;
				t_enter <= '0;
				t_exit  <= '0;
			end
		end
	end

`ifndef SYNTHESIS
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> t_enter <= t_exit)
		else $error("entry parameter beyond exit parameter");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> t_enter == '0 && t_exit == '0)
		else $error("miss word carries nonzero parameters");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> t_exit <= (FRAC_BITS+1)'(1 << FRAC_BITS))
		else $error("exit parameter above one");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(vld_s3) && out_valid)
		else $error("pipeline moved during stall");
`endif
endmodule

@@ rtl/core/sbs_slab_div.sv @@
// ----------------------------------------------------------------------------
// Slab parameter divider
// Pipelined restoring divider computing floor(diff * 2^FRAC_BITS / d),
// saturated to [-1, 2^FRAC_BITS + 1]. One quotient bit per stage.
// Input register, step stages and output register advance when en is high.
// ----------------------------------------------------------------------------
module sbs_slab_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [sbs_pkg::DIFF_W-1:0]     diff,
	input  logic signed [sbs_pkg::DIFF_W-1:0]     d,
	output logic signed [FRAC_BITS+2:0]           q
);
	import sbs_pkg::*;

	localparam int QBITS = FRAC_BITS + 1;
	localparam int QW    = FRAC_BITS + 3;
	localparam int RW    = DIFF_W + 1;

	typedef struct packed {
		logic neg;
		logic zero;
		logic sat;
	} div_class_t;

	logic [DIFF_W-1:0] a_abs;
	logic [DIFF_W-1:0] b_abs;
	div_class_t        cls_in;

	logic [RW-1:0]     r_s   [0:QBITS];
	logic [DIFF_W-1:0] b_s   [0:QBITS];
	logic [QBITS-1:0]  qv_s  [0:QBITS];
	div_class_t        cls_s [0:QBITS];

	localparam logic [QBITS-1:0] T_SAT  = QBITS'((1 << FRAC_BITS) + 1);
	localparam logic signed [QW-1:0] Q_SAT = QW'((1 << FRAC_BITS) + 1);

	always_comb begin
		a_abs       = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		b_abs       = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
		cls_in.zero = (diff == '0);
		cls_in.neg  = (diff != '0) && (diff[DIFF_W-1] != d[DIFF_W-1]);
		// quotient at or above 2^(FRAC_BITS+1) saturates anyway
		cls_in.sat  = {1'b0, a_abs} >= {b_abs, 1'b0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]   <= {1'b0, a_abs};
			b_s[0]   <= b_abs;
			qv_s[0]  <= '0;
			cls_s[0] <= cls_in;
		end
	end

	for (genvar i = 0; i < QBITS; i++) begin : g_step
		logic          ge;
		logic [RW-1:0] rem;
		always_comb begin
			ge  = r_s[i] >= {1'b0, b_s[i]};
			rem = ge ? r_s[i] - {1'b0, b_s[i]} : r_s[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[i+1]   <= {rem[RW-2:0], 1'b0};
				b_s[i+1]   <= b_s[i];
				qv_s[i+1]  <= {qv_s[i][QBITS-2:0], ge};
				cls_s[i+1] <= cls_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (cls_s[QBITS].neg)
				q <= '1;
			else if (cls_s[QBITS].zero)
				q <= '0;
			else if (cls_s[QBITS].sat || qv_s[QBITS] > T_SAT)
				q <= Q_SAT;
			else
				q <= QW'({2'b00, qv_s[QBITS]});
		end
	end
endmodule
